/* rtl/core/quantized_loop_tap_player_macros.svh */
// Assertion macros for the loop tap player.
// Used by the top level only; needs aclk and aresetn in scope.
`ifndef QUANTIZED_LOOP_TAP_PLAYER_MACROS_SVH
`define QUANTIZED_LOOP_TAP_PLAYER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define QLTP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define QLTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/qltp_pkg.sv */
// Shared types and constants for the loop tap player.
// No dependencies.
package qltp_pkg;

    localparam int MAX_TAPS_DEF    = 32;
    localparam int INSTRUMENTS_DEF = 6;

    localparam int CT_W = 34;
    localparam int D_W  = 35;

    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_WRITE   = 2'd1,
        FUNC_RESTART = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        CFG_BEAT_LEN  = 3'd0,
        CFG_BAR_LEN   = 3'd1,
        CFG_QUANT     = 3'd2,
        CFG_BAR_NOTE  = 3'd3,
        CFG_BEAT_NOTE = 3'd4
    } cfg_idx_t;

    localparam logic [15:0] BEAT_LEN_RST  = 16'd500;
    localparam logic [15:0] BAR_LEN_RST   = 16'd2000;
    localparam logic [6:0]  BAR_NOTE_RST  = 7'd36;
    localparam logic [6:0]  BEAT_NOTE_RST = 7'd37;

    localparam logic [6:0] BAR_VEL    = 7'd100;
    localparam logic [6:0] BEAT_VEL   = 7'd64;
    localparam logic [2:0] CLICK_LAMP = 3'd4;
    localparam int         WINDOW_MS  = 10;

    typedef struct packed {
        logic [13:0] pulse_len;
        logic [2:0]  lamp;
        logic [6:0]  velocity;
        logic [6:0]  note;
    } ev_t;

    typedef struct packed {
        logic push;
        logic flush;
        ev_t  ev;
    } evq_ctl_t;

    typedef struct packed {
        logic push_ok;
        logic flush_ok;
        logic hold_valid;
    } evq_sts_t;

endpackage

/* rtl/core/qltp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qltp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/core/qltp_rem.sv */
// Iterative floored remainder, one quotient bit per cycle.
// Depends on qltp_pkg.
module qltp_rem
    import qltp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic signed [CT_W-1:0] x,
    input  logic [15:0]            q,
    output logic                   done,
    output logic [15:0]            r
);
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic [CT_W-1:0] m_reg, m_next;
    logic [15:0]     rem_reg, rem_next;
    logic            neg_reg, neg_next;
    logic [15:0]     r_reg, r_next;
    logic [16:0]     sh;
    logic [16:0]     diff;
    logic [15:0]     step_rem;

    always_comb begin
        sh       = {rem_reg, m_reg[CT_W-1]};
        diff     = sh - {1'b0, q};
        step_rem = (sh >= {1'b0, q}) ? diff[15:0] : sh[15:0];
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        m_next    = m_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        r_next    = r_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 6'(CT_W - 1);
            neg_next  = x[CT_W-1];
            m_next    = x[CT_W-1] ? CT_W'(-x) : CT_W'(x);
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = step_rem;
            m_next   = {m_reg[CT_W-2:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                r_next    = (neg_reg && step_rem != '0) ? q - step_rem : step_rem;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        m_reg   <= m_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        r_reg   <= r_next;
    end

    assign done = done_reg;
    assign r    = r_reg;
endmodule

/* rtl/core/qltp_evq.sv */
// Event output stage: one hold entry plus the output register, so the
// last flag is known when an event leaves. Depends on qltp_pkg.
module qltp_evq
    import qltp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  evq_ctl_t    ctl,
    output evq_sts_t    sts,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // note[6:0], velocity[13:7], lamp[16:14], pulse_len[30:17]
    output logic        m_tlast
);
    logic hold_valid_reg, hold_valid_next;
    ev_t  hold_reg, hold_next;
    logic out_valid_reg, out_valid_next;
    ev_t  out_reg, out_next;
    logic last_reg, last_next;
    logic out_free;

    always_comb begin
        out_free        = !out_valid_reg || m_tready;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_next        = out_reg;
        last_next       = last_reg;
        sts.push_ok     = !hold_valid_reg || out_free;
        sts.flush_ok    = !hold_valid_reg || out_free;
        sts.hold_valid  = hold_valid_reg;
        if (ctl.push && sts.push_ok) begin
            if (hold_valid_reg) begin
                out_valid_next = 1'b1;
                out_next       = hold_reg;
                last_next      = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_next       = ctl.ev;
        end else if (ctl.flush && hold_valid_reg && out_free) begin
            out_valid_next  = 1'b1;
            out_next        = hold_reg;
            last_next       = 1'b1;
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        hold_reg <= hold_next;
        out_reg  <= out_next;
        last_reg <= last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};
    assign m_tlast  = last_reg;
endmodule

/* rtl/core/quantized_loop_tap_player.sv */
// Loop tap player for a drum machine: top level with the tick sequencer.
// Depends on qltp_pkg, qltp_ram, qltp_rem, qltp_evq and the macros header.
//
// Input channel s_*: one transaction is a tap write, a loop restart or a
// millisecond tick (s_tuser selects). Writes and restarts leave the sequencer idle.
// A tick that is not paused produces up to MAX_TAPS+1 note-on events on
// m_*, the final one with m_tlast set; a tick may produce none.
// Tick steps: click and bar position (TIMES, CALC), then either the
// remainder unit (quantized mode) or nothing, then a read state and an
// event state per tap in the scan of the tap RAM (one read port), then
// FLUSH releases the last event.
// s_tready is high only while the sequencer is idle.
// The last event of a tick may still sit in the output register when the
// next transaction is taken. A stalled m_tready holds the sequencer at its
// next event; nothing is dropped.
// Reset (aresetn low, synchronous) restores register defaults and clears played
// flags, fired marks and times; the tap RAM is not cleared. Configuration is
// written through cfg_we/cfg_index/cfg_data while idle: a user rule, not enforced.
`include "quantized_loop_tap_player_macros.svh"
module quantized_loop_tap_player
    import qltp_pkg::*;
#(
    parameter int MAX_TAPS    = MAX_TAPS_DEF,
    parameter int INSTRUMENTS = INSTRUMENTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // now_ms[31:0], paused[32], entry_index[37:33], tap_time[53:38],
    // tap_instrument[56:54], tap_note[63:57], tap_velocity[70:64], tap_count[76:71]
    input  logic [79:0] s_tdata,
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // note[6:0], velocity[13:7], lamp[16:14], pulse_len[30:17]
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW    = $clog2(MAX_TAPS + 1);
    localparam int TAP_W = 33;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_TIMES = 7'b0000010,
        ST_CALC  = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_RD    = 7'b0010000,
        ST_EV    = 7'b0100000,
        ST_FLUSH = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] beat_len_reg, bar_len_reg, qp_reg;
    logic [6:0]  bar_note_reg, beat_note_reg;
    logic [31:0] now_reg, nbar_reg, nbeat_reg;
    logic signed [CT_W-1:0] ct_reg;
    logic [CW-1:0] idx_reg, total_reg;
    logic [MAX_TAPS-1:0]    played_reg;
    logic [INSTRUMENTS-1:0] fired_reg;
    logic slot_reg;

    // input fields
    func_t       in_func;
    logic [31:0] in_now;
    logic        in_paused;
    logic [4:0]  in_entry;
    logic [15:0] in_time;
    logic [2:0]  in_ins;
    logic [6:0]  in_note, in_vel;
    logic [5:0]  in_count;
    logic        s_acc;

    assign in_func   = func_t'(s_tuser);
    assign in_now    = s_tdata[31:0];
    assign in_paused = s_tdata[32];
    assign in_entry  = s_tdata[37:33];
    assign in_time   = s_tdata[53:38];
    assign in_ins    = s_tdata[56:54];
    assign in_note   = s_tdata[63:57];
    assign in_vel    = s_tdata[70:64];
    assign in_count  = s_tdata[76:71];
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;

    // tap RAM
    logic             ram_we;
    logic [TAP_W-1:0] ram_rdata;
    logic [15:0]      t_time;
    logic [2:0]       t_ins;
    logic [6:0]       t_note, t_vel;

    assign ram_we = s_acc && in_func == FUNC_WRITE && 32'(in_entry) < MAX_TAPS;

    qltp_ram #(.WIDTH(TAP_W), .DEPTH(MAX_TAPS)) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(AW'(in_entry)),
        .wdata({in_time, in_ins, in_note, in_vel}),
        .raddr(idx_reg[AW-1:0]),
        .rdata(ram_rdata)
    );
    assign {t_time, t_ins, t_note, t_vel} = ram_rdata;

    // remainder unit
    logic        rem_start, rem_done;
    logic [15:0] rem_r;
    logic [15:0] h;
    logic        quant;
    logic signed [CT_W-1:0] ct_calc;

    assign h         = {1'b0, qp_reg[15:1]};
    assign quant     = (qp_reg != '0);
    assign rem_start = (state_reg == ST_CALC) && quant;

    qltp_rem u_rem (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (rem_start),
        .x      (ct_calc + $signed({18'b0, h})),
        .q      (qp_reg),
        .done   (rem_done),
        .r      (rem_r)
    );

    // event queue
    evq_ctl_t evq_ctl;
    evq_sts_t evq_sts;

    qltp_evq u_evq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (evq_ctl),
        .sts     (evq_sts),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    // datapath
    logic [31:0]       sd_bar, sd_beat;
    logic [32:0]       near_sum;
    logic              bar_hit, beat_hit, near_bar;
    logic signed [D_W-1:0]  d, dp, dm;
    logic              in_q, in_u, gated, played_cur, tap_hit, last_tap;
    ev_t               bar_ev, beat_ev, tap_ev;

    always_comb begin
        sd_bar   = now_reg - nbar_reg;
        sd_beat  = now_reg - nbeat_reg;
        bar_hit  = !sd_bar[31];
        beat_hit = !sd_beat[31];
        near_sum = {sd_bar[31], sd_bar} + {17'b0, h};
        near_bar = !near_sum[32] && near_sum != '0;
        ct_calc  = $signed({{2{sd_bar[31]}}, sd_bar}) + $signed({18'b0, bar_len_reg});
        d        = $signed({19'b0, t_time}) - $signed({ct_reg[CT_W-1], ct_reg});
        dp       = d + $signed({19'b0, h});
        dm       = d - $signed({19'b0, h});
        in_q     = !dp[D_W-1] && dm[D_W-1];
        in_u     = (d > -D_W'(WINDOW_MS)) && (d < D_W'(WINDOW_MS));
        gated    = 1'b0;
        for (int k = 0; k < INSTRUMENTS; k++) begin
            if (t_ins == 3'(k) && fired_reg[k]) begin
                gated = 1'b1;
            end
        end
        played_cur = played_reg[idx_reg[AW-1:0]];
        tap_hit    = quant ? (!gated && in_q) : (in_u && !played_cur);
        last_tap   = (idx_reg + CW'(1)) == total_reg;

        bar_ev  = '{pulse_len: beat_len_reg[15:2], lamp: CLICK_LAMP,
                    velocity: BAR_VEL, note: bar_note_reg};
        beat_ev = '{pulse_len: 14'(beat_len_reg[15:5]), lamp: CLICK_LAMP,
                    velocity: BEAT_VEL, note: beat_note_reg};
        tap_ev  = '{pulse_len: 14'(t_vel[6:5]), lamp: t_ins,
                    velocity: t_vel, note: t_note};

        evq_ctl.push  = 1'b0;
        evq_ctl.flush = (state_reg == ST_FLUSH);
        evq_ctl.ev    = tap_ev;
        unique case (state_reg)
            ST_TIMES: begin
                evq_ctl.push = bar_hit || beat_hit;
                evq_ctl.ev   = bar_hit ? bar_ev : beat_ev;
            end
            ST_EV: begin
                evq_ctl.push = tap_hit;
            end
            default: begin
            end
        endcase
    end

    // sequencer
    logic [31:0]            nbar_next, nbeat_next;
    logic [CW-1:0]          idx_next, total_next;
    logic [MAX_TAPS-1:0]    played_next;
    logic [INSTRUMENTS-1:0] fired_next;
    logic                   slot_next;
    logic [31:0]            now_next;
    logic signed [CT_W-1:0] ct_next;

    always_comb begin
        state_next  = state_reg;
        nbar_next   = nbar_reg;
        nbeat_next  = nbeat_reg;
        idx_next    = idx_reg;
        total_next  = total_reg;
        played_next = played_reg;
        fired_next  = fired_reg;
        slot_next   = slot_reg;
        now_next    = now_reg;
        ct_next     = ct_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    now_next = in_now;
                    if (in_func == FUNC_RESTART) begin
                        total_next  = (32'(in_count) > MAX_TAPS) ? CW'(MAX_TAPS) : CW'(in_count);
                        nbar_next   = in_now;
                        nbeat_next  = in_now;
                        played_next = '0;
                        fired_next  = '0;
                        slot_next   = 1'b0;
                    end else if (in_func == FUNC_TICK && !in_paused) begin
                        state_next = ST_TIMES;
                    end
                end
                if (cfg_we && cfg_idx_t'(cfg_index) == CFG_QUANT) begin
                    fired_next = '0;
                    slot_next  = 1'b0;
                end
            end
            ST_TIMES: begin
                if (!evq_ctl.push || evq_sts.push_ok) begin
                    state_next = ST_CALC;
                    if (bar_hit) begin
                        nbar_next  = nbar_reg + 32'(bar_len_reg);
                        nbeat_next = nbeat_reg + 32'(beat_len_reg);
                        for (int k = 0; k < MAX_TAPS; k++) begin
                            if (k < 32'(total_reg)) begin
                                played_next[k] = 1'b0;
                            end
                        end
                    end else begin
                        if (beat_hit) begin
                            nbeat_next = nbeat_reg + 32'(beat_len_reg);
                        end
                        if (quant && near_bar) begin
                            fired_next = '0;
                        end
                    end
                end
            end
            ST_CALC: begin
                ct_next  = ct_calc;
                idx_next = '0;
                if (quant) begin
                    state_next = ST_DIV;
                end else if (total_reg == '0) begin
                    state_next = ST_FLUSH;
                end else begin
                    state_next = ST_RD;
                end
            end
            ST_DIV: begin
                if (rem_done) begin
                    if (rem_r < h) begin
                        slot_next  = 1'b0;
                        fired_next = '0;
                        state_next = ST_FLUSH;
                    end else if (slot_reg) begin
                        state_next = ST_FLUSH;
                    end else begin
                        slot_next  = 1'b1;
                        state_next = (total_reg == '0) ? ST_FLUSH : ST_RD;
                    end
                end
            end
            ST_RD: begin
                state_next = ST_EV;
            end
            ST_EV: begin
                if (!tap_hit || evq_sts.push_ok) begin
                    if (quant) begin
                        if (gated || in_q) begin
                            played_next[idx_reg[AW-1:0]] = 1'b1;
                        end
                        if (tap_hit) begin
                            for (int k = 0; k < INSTRUMENTS; k++) begin
                                if (t_ins == 3'(k)) begin
                                    fired_next[k] = 1'b1;
                                end
                            end
                        end
                    end else begin
                        played_next[idx_reg[AW-1:0]] = in_u;
                    end
                    idx_next   = idx_reg + CW'(1);
                    state_next = last_tap ? ST_FLUSH : ST_RD;
                end
            end
            ST_FLUSH: begin
                if (evq_sts.flush_ok) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            beat_len_reg  <= BEAT_LEN_RST;
            bar_len_reg   <= BAR_LEN_RST;
            qp_reg        <= '0;
            bar_note_reg  <= BAR_NOTE_RST;
            beat_note_reg <= BEAT_NOTE_RST;
            nbar_reg      <= '0;
            nbeat_reg     <= '0;
            total_reg     <= '0;
            played_reg    <= '0;
            fired_reg     <= '0;
            slot_reg      <= 1'b0;
            idx_reg       <= '0;
        end else begin
            state_reg  <= state_next;
            nbar_reg   <= nbar_next;
            nbeat_reg  <= nbeat_next;
            total_reg  <= total_next;
            played_reg <= played_next;
            fired_reg  <= fired_next;
            slot_reg   <= slot_next;
            idx_reg    <= idx_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_BEAT_LEN:  beat_len_reg  <= cfg_data;
                    CFG_BAR_LEN:   bar_len_reg   <= cfg_data;
                    CFG_QUANT:     qp_reg        <= cfg_data;
                    CFG_BAR_NOTE:  bar_note_reg  <= cfg_data[6:0];
                    CFG_BEAT_NOTE: beat_note_reg <= cfg_data[6:0];
                    default: begin
                    end
                endcase
            end
        end
        now_reg <= now_next;
        ct_reg  <= ct_next;
    end

    `QLTP_ASSERT_NOW(a_rem_done_in_div, rem_done, state_reg == ST_DIV, "remainder done outside DIV")
    `QLTP_ASSERT_NOW(a_scan_in_range, state_reg == ST_EV, idx_reg < total_reg, "tap index past total")
    `QLTP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")
    `QLTP_ASSERT_NEXT(a_flush_idle, state_reg == ST_FLUSH && evq_sts.flush_ok, !evq_sts.hold_valid, "flush left event")

endmodule
